>>> rtl/pac_pkg.sv
package pac_pkg;

  // Oscillator bank.
  localparam int NUM_OSC = 64;
  localparam int OSC_AW  = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
  localparam int SEL_W   = 6;
  localparam int STEP_W  = 32;
  localparam int PHASE_W = 32;
  localparam int COS_W   = 32;

  // Stream payloads, padded to whole bytes.
  localparam int IN_DATA_W  = ((SEL_W + STEP_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SEL_W + COS_W + 7) / 8) * 8;

  // Configuration registers.
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ZERO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FOUR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SIX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_EIGHT  = 3'd5;

  localparam logic [CFG_W-1:0] RST_PHASE_SCALE = 31'd843314857;
  localparam logic [CFG_W-1:0] RST_COEF_ZERO   = 31'd1073741824;
  localparam logic [CFG_W-1:0] RST_COEF_TWO    = 31'd536870912;
  localparam logic [CFG_W-1:0] RST_COEF_FOUR   = 31'd44739243;
  localparam logic [CFG_W-1:0] RST_COEF_SIX    = 31'd1491308;
  localparam logic [CFG_W-1:0] RST_COEF_EIGHT  = 31'd26630;

  // Shared multiplier: 64 x 64 operands worked as four 32 x 32 partial products.
  localparam int MUL_W  = 64;
  localparam int HALF_W = 32;
  localparam int PROD_W = 128;

  // Fixed-point widths of the intermediate values (all unsigned magnitudes).
  localparam int ANG_W    = 32;  // |x|, Q3.28, at most 2^31
  localparam int X2_W     = 35;
  localparam int X4_W     = 41;
  localparam int X6_W     = 47;
  localparam int X8_W     = 53;
  localparam int TERM_W   = 57;
  localparam int SUM_W    = 58;
  localparam int SH_ANG   = 31;
  localparam int SH_POW   = 28;
  localparam int SH_TERM  = 29;

  // Multiply operations in sequence order.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_SCALE = 4'd0;
  localparam logic [OP_W-1:0] OP_X2    = 4'd1;
  localparam logic [OP_W-1:0] OP_X4    = 4'd2;
  localparam logic [OP_W-1:0] OP_X6    = 4'd3;
  localparam logic [OP_W-1:0] OP_X8    = 4'd4;
  localparam logic [OP_W-1:0] OP_T2    = 4'd5;
  localparam logic [OP_W-1:0] OP_T4    = 4'd6;
  localparam logic [OP_W-1:0] OP_T6    = 4'd7;
  localparam logic [OP_W-1:0] OP_T8    = 4'd8;

endpackage

>>> rtl/phase_accumulator_taylor_cosine.sv
// Bank of 64 numerically controlled oscillators with a polynomial cosine
// output. Each input item names one oscillator and carries its signed phase
// step; the block reads that oscillator's stored phase, maps it to an angle x
// in Q3.28 with the phase_scale register, returns one item holding the
// oscillator number and c0 - c2*x^2 + c4*x^4 - c6*x^6 + c8*x^8 in signed
// Q2.29 (saturated to 32 bits), and stores the phase advanced by the step,
// wrapping modulo 2^32. All arithmetic truncates. An oscillator number beyond
// the bank reads a zero phase and its step is dropped, but still yields a
// result. Phases are zero after reset. The block works on one item at a
// time. Nine dependent products (the angle, four powers of x and four series
// terms) all go through one shared 32 x 32 multiplier; each is issued, its
// four partial products are formed and registered in turn, summed into the
// accumulator and handed back with a done flag. The phase is read as the
// item is accepted, and the finished sum is loaded into the output register.
// The input side is ready again once the result sits in the output register,
// even if the downstream side has not yet taken it. Configuration writes are
// always taken and must only be issued while the block is idle; a write to an
// index past the last register is ignored.
module phase_accumulator_taylor_cosine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input items: [5:0] osc_select, [37:6] phase_step, [39:38] zero.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [pac_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // Result items: [5:0] osc_echo, [37:6] cosine_value, [39:38] zero.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [pac_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // Register writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pac_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pac_pkg::CFG_W-1:0]      cfg_data_i
);
  import pac_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam int SEL_EXT_W = SEL_W + OSC_AW;

  // Control state.
  logic [2:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q;
  logic              out_valid_q;

  // Configuration registers.
  logic [CFG_W-1:0]  scale_q, coef0_q, coef2_q, coef4_q, coef6_q, coef8_q;

  // Phase store: memory plus one valid bit per oscillator so that reset reads zero.
  logic [PHASE_W-1:0] phase_mem [NUM_OSC];
  logic [NUM_OSC-1:0] phase_vld_q;
  logic [PHASE_W-1:0] rd_q;
  logic               rd_vld_q;

  // Item payload and working values.
  logic [SEL_W-1:0]   sel_q;
  logic [STEP_W-1:0]  step_q;
  logic [OSC_AW-1:0]  idx_q;
  logic               in_range_q;
  logic               pneg_q;
  logic [PHASE_W-1:0] pabs_q;
  logic [ANG_W-1:0]   ang_q;
  logic [X2_W-1:0]    x2_q;
  logic [X4_W-1:0]    x4_q;
  logic [X6_W-1:0]    x6_q;
  logic [X8_W-1:0]    x8_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [OUT_DATA_W-1:0]   out_data_q;

  // Decode of the incoming item.
  logic [SEL_W-1:0]     in_sel;
  logic [SEL_EXT_W-1:0] in_sel_ext;
  logic [OSC_AW-1:0]    in_idx;
  logic                 in_range;
  logic                 in_accept;

  assign in_sel     = s_axis_tdata_i[SEL_W-1:0];
  assign in_sel_ext = SEL_EXT_W'(in_sel);
  assign in_idx     = in_sel_ext[OSC_AW-1:0];
  assign in_range   = in_sel_ext < SEL_EXT_W'(NUM_OSC);
  assign in_accept  = s_axis_tvalid_i && s_axis_tready_o;

  // Old phase and its magnitude.
  logic [PHASE_W-1:0] phase_old, phase_abs;
  assign phase_old = rd_vld_q ? rd_q : '0;
  assign phase_abs = phase_old[PHASE_W-1] ? (~phase_old + PHASE_W'(1)) : phase_old;

  // Shared multiplier and its operand selection.
  logic              mul_start, mul_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;

  assign mul_start = (state_q == ST_ISSUE);

  always_comb begin
    case (op_q)
      OP_SCALE: begin
        mul_a = MUL_W'(pabs_q);
        mul_b = MUL_W'(scale_q);
      end
      OP_X2: begin
        mul_a = MUL_W'(ang_q);
        mul_b = MUL_W'(ang_q);
      end
      OP_X4: begin
        mul_a = MUL_W'(x2_q);
        mul_b = MUL_W'(x2_q);
      end
      OP_X6: begin
        mul_a = MUL_W'(x4_q);
        mul_b = MUL_W'(x2_q);
      end
      OP_X8: begin
        mul_a = MUL_W'(x6_q);
        mul_b = MUL_W'(x2_q);
      end
      OP_T2: begin
        mul_a = MUL_W'(x2_q);
        mul_b = MUL_W'(coef2_q);
      end
      OP_T4: begin
        mul_a = MUL_W'(x4_q);
        mul_b = MUL_W'(coef4_q);
      end
      OP_T6: begin
        mul_a = MUL_W'(x6_q);
        mul_b = MUL_W'(coef6_q);
      end
      OP_T8: begin
        mul_a = MUL_W'(x8_q);
        mul_b = MUL_W'(coef8_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pac_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // The angle is floor(p * scale / 2^31); for a negative phase the magnitude
  // of that floor is the ceiling of |p| * scale / 2^31, hence the rounding bias.
  logic [MUL_W-1:0] ang_sum;
  assign ang_sum = {1'b0, mul_prod[MUL_W-2:0]} + {{(MUL_W-SH_ANG){1'b0}}, {SH_ANG{pneg_q}}};

  // Series terms as signed addends.
  logic signed [SUM_W-1:0] term;
  assign term = $signed({{(SUM_W-TERM_W){1'b0}}, mul_prod[SH_TERM+TERM_W-1:SH_TERM]});

  // Saturate the wide sum to the 32-bit result.
  logic             sat_pos, sat_neg;
  logic [COS_W-1:0] cos_val;
  assign sat_pos = !sum_q[SUM_W-1] && (|sum_q[SUM_W-2:COS_W-1]);
  assign sat_neg = sum_q[SUM_W-1] && !(&sum_q[SUM_W-2:COS_W-1]);
  always_comb begin
    if (sat_pos) begin
      cos_val = {1'b0, {(COS_W-1){1'b1}}};
    end else if (sat_neg) begin
      cos_val = {1'b1, {(COS_W-1){1'b0}}};
    end else begin
      cos_val = sum_q[COS_W-1:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD:  state_d = ST_ISSUE;
      ST_ISSUE: state_d = ST_MUL;
      ST_MUL: begin
        if (mul_done) begin
          state_d = (op_q == OP_T8) ? ST_OUT : ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_SCALE;
      out_valid_q <= 1'b0;
      phase_vld_q <= '0;
      scale_q     <= RST_PHASE_SCALE;
      coef0_q     <= RST_COEF_ZERO;
      coef2_q     <= RST_COEF_TWO;
      coef4_q     <= RST_COEF_FOUR;
      coef6_q     <= RST_COEF_SIX;
      coef8_q     <= RST_COEF_EIGHT;
    end else begin
      state_q <= state_d;
      if (state_q == ST_LOAD) begin
        op_q <= OP_SCALE;
        if (in_range_q) begin
          phase_vld_q[idx_q] <= 1'b1;
        end
      end else if (state_q == ST_MUL && mul_done && op_q != OP_T8) begin
        op_q <= op_q + OP_W'(1);
      end
      if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_PHASE_SCALE: scale_q <= cfg_data_i;
          REG_COEF_ZERO:   coef0_q <= cfg_data_i;
          REG_COEF_TWO:    coef2_q <= cfg_data_i;
          REG_COEF_FOUR:   coef4_q <= cfg_data_i;
          REG_COEF_SIX:    coef6_q <= cfg_data_i;
          REG_COEF_EIGHT:  coef8_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Phase memory: read on acceptance, written back with the advanced phase.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_q <= phase_mem[in_idx];
    end
    if (state_q == ST_LOAD && in_range_q) begin
      phase_mem[idx_q] <= phase_old + step_q;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sel_q      <= in_sel;
      step_q     <= s_axis_tdata_i[SEL_W+STEP_W-1:SEL_W];
      idx_q      <= in_idx;
      in_range_q <= in_range;
      rd_vld_q   <= in_range && phase_vld_q[in_idx];
    end
    if (state_q == ST_LOAD) begin
      pneg_q <= phase_old[PHASE_W-1];
      pabs_q <= phase_abs;
      sum_q  <= $signed({{(SUM_W-CFG_W+1){1'b0}}, coef0_q[CFG_W-1:1]});
    end
    if (state_q == ST_MUL && mul_done) begin
      case (op_q)
        OP_SCALE: ang_q <= ang_sum[SH_ANG+ANG_W-1:SH_ANG];
        OP_X2:    x2_q  <= mul_prod[SH_POW+X2_W-1:SH_POW];
        OP_X4:    x4_q  <= mul_prod[SH_POW+X4_W-1:SH_POW];
        OP_X6:    x6_q  <= mul_prod[SH_POW+X6_W-1:SH_POW];
        OP_X8:    x8_q  <= mul_prod[SH_POW+X8_W-1:SH_POW];
        OP_T2:    sum_q <= sum_q - term;
        OP_T4:    sum_q <= sum_q + term;
        OP_T6:    sum_q <= sum_q - term;
        OP_T8:    sum_q <= sum_q + term;
        default: ;
      endcase
    end
    if (state_q == ST_OUT && out_free) begin
      out_data_q <= OUT_DATA_W'({cos_val, sel_q});
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign cfg_ready_o     = 1'b1;

endmodule

>>> rtl/pac_mul.sv
module pac_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pac_pkg::MUL_W-1:0]  a_i,
  input  logic [pac_pkg::MUL_W-1:0]  b_i,
  output logic                       done_o,
  output logic [pac_pkg::PROD_W-1:0] prod_o
);
  import pac_pkg::*;

  logic [MUL_W-1:0]  a_q, b_q;
  logic [1:0]        cnt_q;
  logic              busy_q;
  logic [MUL_W-1:0]  pp_q, pp_d;
  logic [1:0]        pp_sh_q;
  logic              pp_v_q, pp_last_q, done_q;
  logic [PROD_W-1:0] acc_q, pp_ext;
  logic [HALF_W-1:0] a_chunk, b_chunk;

  assign a_chunk = cnt_q[0] ? a_q[MUL_W-1:HALF_W] : a_q[HALF_W-1:0];
  assign b_chunk = cnt_q[1] ? b_q[MUL_W-1:HALF_W] : b_q[HALF_W-1:0];
  assign pp_d    = {{(MUL_W-HALF_W){1'b0}}, a_chunk} * {{(MUL_W-HALF_W){1'b0}}, b_chunk};

  // Place the registered partial product at its weight.
  always_comb begin
    case (pp_sh_q)
      2'd0:    pp_ext = {{(PROD_W-MUL_W){1'b0}}, pp_q};
      2'd1:    pp_ext = {{(PROD_W-MUL_W-HALF_W){1'b0}}, pp_q, {HALF_W{1'b0}}};
      default: pp_ext = {pp_q, {(PROD_W-MUL_W){1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= 2'd0;
      pp_v_q    <= 1'b0;
      pp_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      pp_v_q    <= busy_q;
      pp_last_q <= busy_q && (cnt_q == 2'd3);
      done_q    <= pp_v_q && pp_last_q;
      if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      pp_q    <= pp_d;
      pp_sh_q <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
    end
    if (pp_v_q) begin
      acc_q <= acc_q + pp_ext;
    end
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> rtl/pac_checker.sv
module pac_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [pac_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import pac_pkg::*;

  // The block works on one item at a time: it is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while an item was still in work");

  // A new result only shows up as the item finishes, when input is open again.
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("result appeared while the block was still busy");

  // No result can appear in the cycle right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o) |=> !m_axis_tvalid_o)
    else $error("result appeared too early");

  // A stalled result holds its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  // Padding bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OUT_DATA_W-1:SEL_W+COS_W] == '0))
    else $error("result padding not zero");

endmodule

bind phase_accumulator_taylor_cosine pac_checker u_pac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
